// ----- rtl/core/rbv_pkg.sv -----
`timescale 1ns / 1ps
// rbv_pkg: shared types, widths and rounding helpers for the rotation matrix core
// no dependencies
package rbv_pkg;

  // fixed point format of all vectors and matrix entries
  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int CW        = 16;               // field width
  localparam int PW        = 2 * CW + 1;       // cross product component
  localparam int DW        = 2 * CW + 2;       // dot product
  localparam int NW        = 64;               // squared norm of cross product
  localparam int RW        = NW / 2;           // norm
  localparam int SQW       = 2 * FRAC_BITS + 2; // sine radicand
  localparam int SNW       = SQW / 2;          // sine
  localparam int QB        = FRAC_BITS + 2;    // axis quotient bits
  localparam int XW        = 48;               // working width for rounding

  typedef struct packed {
    logic signed [CW-1:0] before_x;
    logic signed [CW-1:0] before_y;
    logic signed [CW-1:0] before_z;
    logic signed [CW-1:0] after_x;
    logic signed [CW-1:0] after_y;
    logic signed [CW-1:0] after_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] m00;
    logic signed [CW-1:0] m01;
    logic signed [CW-1:0] m02;
    logic signed [CW-1:0] m10;
    logic signed [CW-1:0] m11;
    logic signed [CW-1:0] m12;
    logic signed [CW-1:0] m20;
    logic signed [CW-1:0] m21;
    logic signed [CW-1:0] m22;
  } out_word_t;

  // signed 16x16 product, full width
  function automatic logic signed [2*CW-1:0] smul16(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] y);
    logic signed [2*CW-1:0] xe;
    logic signed [2*CW-1:0] ye;
    xe = (2*CW)'(x);
    ye = (2*CW)'(y);
    return xe * ye;
  endfunction

  // scale down by FRAC_BITS, round to nearest, ties away from zero
  function automatic logic signed [XW-1:0] rnd_shift(input logic signed [XW-1:0] v);
    logic [XW-1:0] mag;
    logic [XW-1:0] q;
    mag = v[XW-1] ? XW'(-v) : XW'(v);
    q   = (mag + XW'(ONE / 2)) >> FRAC_BITS;
    return v[XW-1] ? -$signed(q) : $signed(q);
  endfunction

  // clamp to [-ONE, ONE]
  function automatic logic signed [CW-1:0] sat_unit(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = XW'(ONE);
    lo = -hi;
    if (v > hi) begin
      return CW'(hi);
    end else if (v < lo) begin
      return CW'(lo);
    end else begin
      return v[CW-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/rbv_front.sv -----
`timescale 1ns / 1ps
// rbv_front: products, cross and dot, squared norm, cosine and sine radicand
// depends on rbv_pkg
module rbv_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  rbv_pkg::in_word_t            in_word,
  output logic                         out_valid,
  output logic [rbv_pkg::NW-1:0]       out_n2,
  output logic [2:0][rbv_pkg::PW-1:0]  out_p,
  output logic signed [rbv_pkg::CW-1:0] out_d,
  output logic [rbv_pkg::SQW-1:0]      out_rad,
  output logic                         out_nz
);

  localparam int MW = 2 * rbv_pkg::CW;
  localparam logic signed [MW-1:0] ONE_SQ = MW'(rbv_pkg::ONE * rbv_pkg::ONE);

  logic [3:0] vld_r;

  // stage 1 products
  logic signed [MW-1:0] a1b2_r, a2b1_r, a2b0_r, a0b2_r, a0b1_r, a1b0_r;
  logic signed [MW-1:0] a0b0_r, a1b1_r, a2b2_r;
  // stage 2 cross and dot
  logic signed [rbv_pkg::PW-1:0] p0_r, p1_r, p2_r;
  logic signed [rbv_pkg::DW-1:0] dot_r;
  // stage 3 squares and cosine
  logic [rbv_pkg::NW-1:0] sq0_r, sq1_r, sq2_r;
  logic signed [rbv_pkg::PW-1:0] p0b_r, p1b_r, p2b_r;
  logic signed [rbv_pkg::CW-1:0] d_r;
  logic nz_r;
  // stage 4 norm squared and radicand
  logic [rbv_pkg::NW-1:0] n2_r;
  logic [2:0][rbv_pkg::PW-1:0] pc_r;
  logic signed [rbv_pkg::CW-1:0] dc_r;
  logic [rbv_pkg::SQW-1:0] rad_r;
  logic nzc_r;

  logic signed [2*rbv_pkg::PW-1:0] pe0, pe1, pe2;
  logic signed [MW-1:0] dsq;
  logic signed [MW-1:0] dext;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  assign pe0  = (2*rbv_pkg::PW)'(p0_r);
  assign pe1  = (2*rbv_pkg::PW)'(p1_r);
  assign pe2  = (2*rbv_pkg::PW)'(p2_r);
  assign dext = MW'(d_r);
  assign dsq  = dext * dext;

  // datapath
  always_ff @(posedge clk) begin
    a1b2_r <= rbv_pkg::smul16(in_word.after_y, in_word.before_z);
    a2b1_r <= rbv_pkg::smul16(in_word.after_z, in_word.before_y);
    a2b0_r <= rbv_pkg::smul16(in_word.after_z, in_word.before_x);
    a0b2_r <= rbv_pkg::smul16(in_word.after_x, in_word.before_z);
    a0b1_r <= rbv_pkg::smul16(in_word.after_x, in_word.before_y);
    a1b0_r <= rbv_pkg::smul16(in_word.after_y, in_word.before_x);
    a0b0_r <= rbv_pkg::smul16(in_word.after_x, in_word.before_x);
    a1b1_r <= rbv_pkg::smul16(in_word.after_y, in_word.before_y);
    a2b2_r <= rbv_pkg::smul16(in_word.after_z, in_word.before_z);

    p0_r  <= rbv_pkg::PW'(a1b2_r) - rbv_pkg::PW'(a2b1_r);
    p1_r  <= rbv_pkg::PW'(a2b0_r) - rbv_pkg::PW'(a0b2_r);
    p2_r  <= rbv_pkg::PW'(a0b1_r) - rbv_pkg::PW'(a1b0_r);
    dot_r <= rbv_pkg::DW'(a0b0_r) + rbv_pkg::DW'(a1b1_r) + rbv_pkg::DW'(a2b2_r);

    sq0_r <= rbv_pkg::NW'(pe0 * pe0);
    sq1_r <= rbv_pkg::NW'(pe1 * pe1);
    sq2_r <= rbv_pkg::NW'(pe2 * pe2);
    p0b_r <= p0_r;
    p1b_r <= p1_r;
    p2b_r <= p2_r;
    nz_r  <= (p0_r != '0) || (p1_r != '0) || (p2_r != '0);
    d_r   <= rbv_pkg::sat_unit(rbv_pkg::rnd_shift(rbv_pkg::XW'(dot_r)));

    n2_r  <= sq0_r + sq1_r + sq2_r;
    pc_r  <= {p2b_r, p1b_r, p0b_r};
    dc_r  <= d_r;
    rad_r <= rbv_pkg::SQW'(ONE_SQ - dsq);
    nzc_r <= nz_r;
  end

  assign out_valid = vld_r[3];
  assign out_n2    = n2_r;
  assign out_p     = pc_r;
  assign out_d     = dc_r;
  assign out_rad   = rad_r;
  assign out_nz    = nzc_r;

endmodule

// ----- rtl/core/rbv_isqrt.sv -----
`timescale 1ns / 1ps
// rbv_isqrt: pipelined integer square root, one root bit per stage, side word carried along
// depends on nothing beyond its parameters
module rbv_isqrt #(
  parameter int W  = 64,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [W-1:0]     in_rad,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [W/2-1:0]   out_root,
  output logic [SW-1:0]    out_side
);

  localparam int RW   = W / 2;
  localparam int REMW = RW + 3;

  logic [RW-1:0]   vld_r;
  logic [W-1:0]    rad_r  [RW];
  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SW-1:0]   side_r [RW];

  logic [W-1:0]    rad_i  [RW];
  logic [REMW-1:0] rem_i  [RW];
  logic [RW-1:0]   root_i [RW];
  logic [SW-1:0]   side_i [RW];
  logic [RW-1:0]   vld_i;
  logic [REMW-1:0] rem_nxt  [RW];
  logic [RW-1:0]   root_nxt [RW];

  // stage inputs
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        vld_i[k]  = in_valid;
        rad_i[k]  = in_rad;
        rem_i[k]  = '0;
        root_i[k] = '0;
        side_i[k] = in_side;
      end else begin
        vld_i[k]  = vld_r[k-1];
        rad_i[k]  = rad_r[k-1];
        rem_i[k]  = rem_r[k-1];
        root_i[k] = root_r[k-1];
        side_i[k] = side_r[k-1];
      end
    end
  end

  // one trial subtract per stage
  always_comb begin
    logic [REMW-1:0] sh;
    logic [REMW-1:0] tr;
    for (int k = 0; k < RW; k++) begin
      sh = {rem_i[k][REMW-3:0], rad_i[k][2*(RW-1-k) +: 2]};
      tr = REMW'({root_i[k], 2'b01});
      if (sh >= tr) begin
        rem_nxt[k]  = sh - tr;
        root_nxt[k] = {root_i[k][RW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = sh;
        root_nxt[k] = {root_i[k][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RW; k++) begin
      rad_r[k]  <= rad_i[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      side_r[k] <= side_i[k];
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

// ----- rtl/core/rbv_div.sv -----
`timescale 1ns / 1ps
// rbv_div: three-lane pipelined restoring divider for the axis, rounded magnitudes
// depends on rbv_pkg
module rbv_div #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [rbv_pkg::RW-1:0]        in_den,
  input  logic [2:0][rbv_pkg::PW-1:0]   in_num,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic [2:0][rbv_pkg::QB-1:0]   out_q,
  output logic [SW-1:0]                 out_side
);

  localparam int QB = rbv_pkg::QB;
  localparam int XW = rbv_pkg::XW;
  localparam int NS = QB + 1;

  logic [NS-1:0]             vld_r;
  logic [2:0][XW-1:0]        rem_r  [NS];
  logic [2:0][QB-1:0]        q_r    [NS];
  logic [rbv_pkg::RW-1:0]    den_r  [NS];
  logic [SW-1:0]             side_r [NS];

  logic [2:0][XW-1:0]        num_nxt;
  logic [2:0][XW-1:0]        rem_nxt [QB];
  logic [2:0][QB-1:0]        q_nxt   [QB];

  // rounded numerator: |p| * ONE + den / 2
  always_comb begin
    logic [rbv_pkg::PW-1:0] mag;
    for (int l = 0; l < 3; l++) begin
      mag = in_num[l][rbv_pkg::PW-1] ? -in_num[l] : in_num[l];
      num_nxt[l] = (XW'(mag) << rbv_pkg::FRAC_BITS) + XW'(in_den >> 1);
    end
  end

  // one quotient bit per stage
  always_comb begin
    logic [XW-1:0] sub;
    for (int j = 0; j < QB; j++) begin
      sub = XW'(den_r[j]) << (QB - 1 - j);
      for (int l = 0; l < 3; l++) begin
        q_nxt[j][l] = q_r[j][l];
        if (rem_r[j][l] >= sub) begin
          rem_nxt[j][l] = rem_r[j][l] - sub;
          q_nxt[j][l][QB-1-j] = 1'b1;
        end else begin
          rem_nxt[j][l] = rem_r[j][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= num_nxt;
    q_r[0]    <= '0;
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    for (int j = 0; j < QB; j++) begin
      rem_r[j+1]  <= rem_nxt[j];
      q_r[j+1]    <= q_nxt[j];
      den_r[j+1]  <= den_r[j];
      side_r[j+1] <= side_r[j];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_q     = q_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// ----- rtl/core/rbv_mat.sv -----
`timescale 1ns / 1ps
// rbv_mat: Rodrigues matrix assembly from axis, sine and cosine, with rounding and saturation
// depends on rbv_pkg
module rbv_mat (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [2:0][rbv_pkg::CW-1:0]    in_c,
  input  logic [rbv_pkg::SNW-1:0]        in_s,
  input  logic signed [rbv_pkg::CW-1:0]  in_d,
  output logic                           out_valid,
  output rbv_pkg::out_word_t             out_word
);

  localparam int CW = rbv_pkg::CW;
  localparam int MW = 2 * CW;
  localparam int KW = CW + 2;       // K*K entry
  localparam int OW = CW + 1;       // one minus cosine
  localparam int PW2 = 2 * KW;      // (1-d) * KK product
  localparam int XW = rbv_pkg::XW;

  logic [4:0] vld_r;

  // m1
  logic signed [MW-1:0] c00_r, c11_r, c22_r, c01_r, c02_r, c12_r;
  logic signed [CW-1:0] c0_r, c1_r, c2_r;
  logic [rbv_pkg::SNW-1:0] s_r;
  logic signed [OW-1:0] omc_r;
  // m2
  logic signed [KW-1:0] kd0_r, kd1_r, kd2_r, k01_r, k02_r, k12_r;
  logic signed [CW-1:0] c0b_r, c1b_r, c2b_r;
  logic [rbv_pkg::SNW-1:0] sb_r;
  logic signed [OW-1:0] omcb_r;
  // m3
  logic signed [MW-1:0] sc0_r, sc1_r, sc2_r;
  logic signed [PW2-1:0] od0_r, od1_r, od2_r, o01_r, o02_r, o12_r;
  // m4
  logic signed [CW-1:0] rs0_r, rs1_r, rs2_r;
  logic signed [KW-1:0] rd0_r, rd1_r, rd2_r, r01_r, r02_r, r12_r;
  // m5
  rbv_pkg::out_word_t word_r;

  logic signed [MW-1:0] s_ext;
  logic signed [PW2-1:0] o_ext;
  logic signed [XW-1:0] one_x;

  assign s_ext = MW'($signed({1'b0, sb_r}));
  assign o_ext = PW2'(omcb_r);
  assign one_x = XW'(rbv_pkg::ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // axis products and one minus cosine
    c00_r <= rbv_pkg::smul16(in_c[0], in_c[0]);
    c11_r <= rbv_pkg::smul16(in_c[1], in_c[1]);
    c22_r <= rbv_pkg::smul16(in_c[2], in_c[2]);
    c01_r <= rbv_pkg::smul16(in_c[0], in_c[1]);
    c02_r <= rbv_pkg::smul16(in_c[0], in_c[2]);
    c12_r <= rbv_pkg::smul16(in_c[1], in_c[2]);
    c0_r  <= in_c[0];
    c1_r  <= in_c[1];
    c2_r  <= in_c[2];
    s_r   <= in_s;
    omc_r <= OW'(rbv_pkg::ONE) - OW'(in_d);

    // K*K entries, rounded to fraction format
    kd0_r <= KW'(rbv_pkg::rnd_shift(-(XW'(c22_r) + XW'(c11_r))));
    kd1_r <= KW'(rbv_pkg::rnd_shift(-(XW'(c22_r) + XW'(c00_r))));
    kd2_r <= KW'(rbv_pkg::rnd_shift(-(XW'(c11_r) + XW'(c00_r))));
    k01_r <= KW'(rbv_pkg::rnd_shift(XW'(c01_r)));
    k02_r <= KW'(rbv_pkg::rnd_shift(XW'(c02_r)));
    k12_r <= KW'(rbv_pkg::rnd_shift(XW'(c12_r)));
    c0b_r  <= c0_r;
    c1b_r  <= c1_r;
    c2b_r  <= c2_r;
    sb_r   <= s_r;
    omcb_r <= omc_r;

    // sine and one minus cosine scaling
    sc0_r <= s_ext * MW'(c0b_r);
    sc1_r <= s_ext * MW'(c1b_r);
    sc2_r <= s_ext * MW'(c2b_r);
    od0_r <= o_ext * PW2'(kd0_r);
    od1_r <= o_ext * PW2'(kd1_r);
    od2_r <= o_ext * PW2'(kd2_r);
    o01_r <= o_ext * PW2'(k01_r);
    o02_r <= o_ext * PW2'(k02_r);
    o12_r <= o_ext * PW2'(k12_r);

    // rounding
    rs0_r <= CW'(rbv_pkg::rnd_shift(XW'(sc0_r)));
    rs1_r <= CW'(rbv_pkg::rnd_shift(XW'(sc1_r)));
    rs2_r <= CW'(rbv_pkg::rnd_shift(XW'(sc2_r)));
    rd0_r <= KW'(rbv_pkg::rnd_shift(XW'(od0_r)));
    rd1_r <= KW'(rbv_pkg::rnd_shift(XW'(od1_r)));
    rd2_r <= KW'(rbv_pkg::rnd_shift(XW'(od2_r)));
    r01_r <= KW'(rbv_pkg::rnd_shift(XW'(o01_r)));
    r02_r <= KW'(rbv_pkg::rnd_shift(XW'(o02_r)));
    r12_r <= KW'(rbv_pkg::rnd_shift(XW'(o12_r)));

    // identity plus both terms, saturated
    word_r.m00 <= rbv_pkg::sat_unit(one_x + XW'(rd0_r));
    word_r.m01 <= rbv_pkg::sat_unit(XW'(r01_r) - XW'(rs2_r));
    word_r.m02 <= rbv_pkg::sat_unit(XW'(r02_r) + XW'(rs1_r));
    word_r.m10 <= rbv_pkg::sat_unit(XW'(r01_r) + XW'(rs2_r));
    word_r.m11 <= rbv_pkg::sat_unit(one_x + XW'(rd1_r));
    word_r.m12 <= rbv_pkg::sat_unit(XW'(r12_r) - XW'(rs0_r));
    word_r.m20 <= rbv_pkg::sat_unit(XW'(r02_r) - XW'(rs1_r));
    word_r.m21 <= rbv_pkg::sat_unit(XW'(r12_r) + XW'(rs0_r));
    word_r.m22 <= rbv_pkg::sat_unit(one_x + XW'(rd2_r));
  end

  assign out_valid = vld_r[4];
  assign out_word  = word_r;

endmodule

// ----- rtl/core/rotation_between_vectors_core.sv -----
`timescale 1ns / 1ps
// rotation_between_vectors_core: top level, Rodrigues matrix between two Q1.14 unit vectors
// depends on rbv_pkg, rbv_front, rbv_isqrt, rbv_div, rbv_mat
//
//   channel | ports                    | handshake
//   input   | start, busy, in_word     | word taken when start high and busy low
//   result  | out_strobe, out_word     | one cycle per word, no back pressure
//
// a new word can be taken every cycle; busy is never raised
// pipeline order: front, norm root, axis divide, sine root, matrix
// the norm square root, one bit per stage, sets the depth
// reset clears the valid bits only; nothing stalls since the receiver cannot hold off
module rotation_between_vectors_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rbv_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output rbv_pkg::out_word_t out_word
);

  localparam int CW  = rbv_pkg::CW;
  localparam int PW  = rbv_pkg::PW;
  localparam int SQW = rbv_pkg::SQW;
  localparam int SW1 = 3 * PW + CW + SQW + 1;
  localparam int SW2 = 3 + CW + SQW + 1;
  localparam int SW3 = 4 * CW;

  logic                    fr_valid;
  logic [rbv_pkg::NW-1:0]  fr_n2;
  logic [2:0][PW-1:0]      fr_p;
  logic signed [CW-1:0]    fr_d;
  logic [SQW-1:0]          fr_rad;
  logic                    fr_nz;

  logic                    nr_valid;
  logic [rbv_pkg::RW-1:0]  nr_root;
  logic [SW1-1:0]          nr_side;
  logic [2:0][PW-1:0]      nr_p;
  logic signed [CW-1:0]    nr_d;
  logic [SQW-1:0]          nr_rad;
  logic                    nr_nz;
  logic [2:0]              nr_neg;

  logic                       dv_valid;
  logic [2:0][rbv_pkg::QB-1:0] dv_q;
  logic [SW2-1:0]             dv_side;
  logic [2:0]                 dv_neg;
  logic signed [CW-1:0]       dv_d;
  logic [SQW-1:0]             dv_rad;
  logic                       dv_nz;
  logic [2:0][CW-1:0]         dv_c;

  logic                       sn_valid;
  logic [rbv_pkg::SNW-1:0]    sn_s;
  logic [SW3-1:0]             sn_side;

  assign busy = 1'b0;

  // cross, dot, squared norm
  rbv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_word   (in_word),
    .out_valid (fr_valid),
    .out_n2    (fr_n2),
    .out_p     (fr_p),
    .out_d     (fr_d),
    .out_rad   (fr_rad),
    .out_nz    (fr_nz)
  );

  // norm of the cross product
  rbv_isqrt #(
    .W  (rbv_pkg::NW),
    .SW (SW1)
  ) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_rad    (fr_n2),
    .in_side   ({fr_p, fr_d, fr_rad, fr_nz}),
    .out_valid (nr_valid),
    .out_root  (nr_root),
    .out_side  (nr_side)
  );

  assign {nr_p, nr_d, nr_rad, nr_nz} = nr_side;
  assign nr_neg = {nr_p[2][PW-1], nr_p[1][PW-1], nr_p[0][PW-1]};

  // axis components
  rbv_div #(
    .SW (SW2)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nr_valid),
    .in_den    (nr_root),
    .in_num    (nr_p),
    .in_side   ({nr_neg, nr_d, nr_rad, nr_nz}),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  assign {dv_neg, dv_d, dv_rad, dv_nz} = dv_side;

  // axis is minus the normalized cross product, zero when parallel
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!dv_nz) begin
        dv_c[l] = '0;
      end else if (dv_neg[l]) begin
        dv_c[l] = CW'(dv_q[l]);
      end else begin
        dv_c[l] = -CW'(dv_q[l]);
      end
    end
  end

  // sine from cosine
  rbv_isqrt #(
    .W  (SQW),
    .SW (SW3)
  ) u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_rad    (dv_rad),
    .in_side   ({dv_c, dv_d}),
    .out_valid (sn_valid),
    .out_root  (sn_s),
    .out_side  (sn_side)
  );

  // matrix assembly
  rbv_mat u_mat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sn_valid),
    .in_c      (sn_side[SW3-1:CW]),
    .in_s      (sn_s),
    .in_d      (sn_side[CW-1:0]),
    .out_valid (out_strobe),
    .out_word  (out_word)
  );

endmodule

// ----- verif/rotation_between_vectors_core_tb.sv -----
`timescale 1ns / 1ps
// rotation_between_vectors_core_tb: self-checking bench for the rotation matrix core
// drives vector pairs, predicts each matrix in longint math, checks words in order
// depends on rbv_pkg and rotation_between_vectors_core
module rotation_between_vectors_core_tb;

  localparam int LATENCY = 73;
  localparam longint UNIT = longint'(1) << rbv_pkg::FRAC_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rbv_pkg::in_word_t in_word = '0;
  logic out_strobe;
  rbv_pkg::out_word_t out_word;

  rbv_pkg::out_word_t matrix_q[$];
  int errors = 0;
  int send_idle_pct = 0;

  // directed stimulus; check_fixed marks rows whose matrix is typed in
  typedef struct {
    rbv_pkg::in_word_t  vec;
    bit                 check_fixed;
    rbv_pkg::out_word_t mat;
  } vec_row_t;

  localparam rbv_pkg::out_word_t IDENT = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                                           16'sd0, 16'sd0, 16'sd0, 16'sd16384};

  vec_row_t rows[$];

  rotation_between_vectors_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_strobe(out_strobe), .out_word(out_word)
  );

  always #4 clk = ~clk;

  // bit-by-bit integer square root
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // divide rounding to nearest, ties away from zero
  function automatic longint div_near(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + longint'(den) / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Rodrigues matrix for one vector pair
  function automatic rbv_pkg::out_word_t rotation_matrix(rbv_pkg::in_word_t w);
    longint b[3];
    longint a[3];
    longint p[3];
    longint c[3];
    longint k[3][3];
    longint kk[3][3];
    longint dot, d, s, omc, acc, v;
    longint unsigned n2, nrm;
    logic signed [15:0] ent[9];
    rbv_pkg::out_word_t r;
    b[0] = w.before_x; b[1] = w.before_y; b[2] = w.before_z;
    a[0] = w.after_x;  a[1] = w.after_y;  a[2] = w.after_z;
    c[0] = 0; c[1] = 0; c[2] = 0;
    p[0] = a[1] * b[2] - a[2] * b[1];
    p[1] = a[2] * b[0] - a[0] * b[2];
    p[2] = a[0] * b[1] - a[1] * b[0];
    if (p[0] != 0 || p[1] != 0 || p[2] != 0) begin
      n2 = 0;
      for (int i = 0; i < 3; i++) n2 += longint'(p[i] * p[i]);
      nrm = int_sqrt(n2);
      for (int i = 0; i < 3; i++) c[i] = clip(-div_near(p[i] * UNIT, nrm), -UNIT, UNIT);
    end
    dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    d = clip(div_near(dot, UNIT), -UNIT, UNIT);
    s = int_sqrt(UNIT * UNIT - d * d);
    omc = UNIT - d;
    k[0][0] = 0;     k[0][1] = -c[2]; k[0][2] = c[1];
    k[1][0] = c[2];  k[1][1] = 0;     k[1][2] = -c[0];
    k[2][0] = -c[1]; k[2][1] = c[0];  k[2][2] = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int m = 0; m < 3; m++) acc += k[i][m] * k[m][j];
        kk[i][j] = div_near(acc, UNIT);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v = (i == j) ? UNIT : 0;
        v += div_near(s * k[i][j], UNIT);
        v += div_near(omc * kk[i][j], UNIT);
        ent[i * 3 + j] = 16'(clip(v, -UNIT, (UNIT > 32767) ? 32767 : UNIT));
      end
    r = '{ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7], ent[8]};
    return r;
  endfunction

  // random component, mostly in -16384..16384, sometimes any 16-bit value
  function automatic logic signed [15:0] rand_comp();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // roughly unit vector from a random direction
  task automatic rand_unit(output logic signed [15:0] x, y, z);
    real fx, fy, fz, n;
    do begin
      fx = $itor($signed($urandom_range(0, 2000)) - 1000);
      fy = $itor($signed($urandom_range(0, 2000)) - 1000);
      fz = $itor($signed($urandom_range(0, 2000)) - 1000);
      n = $sqrt(fx * fx + fy * fy + fz * fz);
    end while (n < 10.0);
    x = 16'($rtoi(fx / n * 16384.0));
    y = 16'($rtoi(fy / n * 16384.0));
    z = 16'($rtoi(fz / n * 16384.0));
  endtask

  // append one directed row
  task automatic add_row(input int bx, by, bz, ax, ay, az, input bit fix_mat);
    vec_row_t r;
    r.vec.before_x = 16'(bx);
    r.vec.before_y = 16'(by);
    r.vec.before_z = 16'(bz);
    r.vec.after_x  = 16'(ax);
    r.vec.after_y  = 16'(ay);
    r.vec.after_z  = 16'(az);
    r.check_fixed  = fix_mat;
    r.mat          = IDENT;
    rows = {rows, r};
  endtask

  // hand one word to the core; start stays high until the sender idles, the next word or the end
  task automatic send_word(rbv_pkg::in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    matrix_q = {matrix_q, rotation_matrix(w)};
  endtask

  task automatic check_field(string name, logic signed [15:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (matrix_q.size() == 0) begin
        $error("out_word arrived with no matrix expected");
        errors++;
      end else begin
        rbv_pkg::out_word_t e;
        e = matrix_q.pop_front();
        check_field("m00", e.m00, out_word.m00);
        check_field("m01", e.m01, out_word.m01);
        check_field("m02", e.m02, out_word.m02);
        check_field("m10", e.m10, out_word.m10);
        check_field("m11", e.m11, out_word.m11);
        check_field("m12", e.m12, out_word.m12);
        check_field("m20", e.m20, out_word.m20);
        check_field("m21", e.m21, out_word.m21);
        check_field("m22", e.m22, out_word.m22);
      end
    end
  end

  initial begin
    rbv_pkg::in_word_t w;
    logic signed [15:0] x, y, z;
    int wait_cnt;
    // parallel, opposite and zero vectors give the identity
    add_row(16384, 0, 0, 16384, 0, 0, 1'b1);
    add_row(16384, 0, 0, -16384, 0, 0, 1'b1);
    add_row(0, -16384, 0, 0, 16384, 0, 1'b1);
    add_row(0, 0, 0, 0, 0, 0, 1'b1);
    add_row(0, 0, 16384, 0, 0, 16384, 1'b1);
    // quarter turns about each axis
    add_row(16384, 0, 0, 0, 16384, 0, 1'b0);
    add_row(0, 16384, 0, 0, 0, 16384, 1'b0);
    add_row(0, 0, 16384, 16384, 0, 0, 1'b0);
    add_row(0, 16384, 0, 16384, 0, 0, 1'b0);
    // field extremes and cosine out of range
    add_row(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0);
    add_row(32767, 32767, 32767, 32767, 32767, -32768, 1'b0);
    add_row(-32768, 32767, 0, 32767, -32768, 1, 1'b0);
    add_row(-1, -1, -1, 1, 1, -1, 1'b0);
    add_row(11585, 11585, 0, 0, 11585, 11585, 1'b0);
    add_row(16384, 0, 0, -16384, 1, 0, 1'b0);
    add_row(-16384, 16384, -16384, 16384, -16384, 16384, 1'b0);
    add_row(1, 0, 0, 0, 0, 1, 1'b0);
    add_row(21845, -21846, 10922, -5461, 5461, 21845, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_word(rows[i].vec);
      // typed-in identity replaces the predicted matrix
      if (rows[i].check_fixed) begin
        matrix_q[matrix_q.size() - 1] = rows[i].mat;
      end
    end

    // random phases: no idling, then sender idle 58 of 100, then 17
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 0 : ((ph == 1) ? 58 : 17);
      for (int n = 0; n < 220; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          rand_unit(x, y, z);
          w.before_x = x; w.before_y = y; w.before_z = z;
          case ($urandom_range(0, 5))
            0: begin
              w.after_x = x; w.after_y = y; w.after_z = z;
            end
            1: begin
              w.after_x = -x; w.after_y = -y; w.after_z = -z;
            end
            default: begin
              rand_unit(x, y, z);
              w.after_x = x; w.after_y = y; w.after_z = z;
            end
          endcase
        end else begin
          w.before_x = rand_comp(); w.before_y = rand_comp(); w.before_z = rand_comp();
          w.after_x = rand_comp(); w.after_y = rand_comp(); w.after_z = rand_comp();
        end
        send_word(w);
        // occasionally the next word follows back-to-back
        if (ph != 0 && $urandom_range(0, 19) == 0) send_idle_pct = 0;
        else send_idle_pct = (ph == 0) ? 0 : ((ph == 1) ? 58 : 17);
      end
    end
    start <= 1'b0;

    // drain
    wait_cnt = 0;
    while (matrix_q.size() != 0 && wait_cnt < 20 * LATENCY) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("rotation_between_vectors_core regression: pass");
    end else begin
      $display("rotation_between_vectors_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("rotation_between_vectors_core regression: fail");
    $finish;
  end

endmodule
